[hdl/lcs_pkg.sv]
package lcs_pkg;

   // Width of one element value and of the configuration write data
   localparam int VAL_W   = 6;
   localparam int POS_W   = 4;
   localparam int SET_W   = 6;
   localparam int SUB_W   = 5;
   localparam int CSR_W   = 1;

   // Configuration register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_SET_SIZE    = 1'b0,
      CSR_SUBSET_SIZE = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_REFILL,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // Result of the shared compare / increment unit
   typedef struct packed {
      logic             below_ceiling;
      logic [VAL_W-1:0] incremented;
   } alu_res_type;

endpackage

[hdl/lcs_store.sv]
module lcs_store
   import lcs_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lcs_alu.sv]
module lcs_alu
   import lcs_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic [VAL_W-1:0] operand,
   input  logic [SET_W-1:0] set_size,
   input  logic [IDX_W-1:0] position,
   input  logic [IDX_W-1:0] last_position,
   output alu_res_type      result
);

   logic [7:0] ceiling;

   // Ceiling of a position is n - k + 1 + position; k <= n whenever it is used
   assign ceiling = 8'(set_size) + 8'(position) - 8'(last_position);

   assign result.below_ceiling = (8'(operand) < ceiling);
   assign result.incremented   = operand + VAL_W'(1);

endmodule

[hdl/lexicographic_combination_step.sv]
// Lexicographic k-subset generator. Each accepted request (restart = 1 starts over at 1..k,
// restart = 0 moves to the next subset) produces k response transactions, one per element,
// in position order, each carrying the element value, a last mark and the finished flag.
// After reset, after restart and after the list ran out, the request loads 1..k; when no
// further subset exists the flag is set and the subset is repeated unchanged. All work runs
// through one element store with a registered read port and one shared compare/increment
// unit. Loading 1..k writes the elements in position order; an advance reads and checks
// elements from the last one backwards, bumps the first one below its ceiling and refills
// the tail after it with successive values; a request with k above n skips the advance.
// Each element is then read and emitted; emission holds while the response side is not ready.
// The block takes no request until the last element has been taken.
// Configuration writes are always ready and must only occur while the block is idle.
module lexicographic_combination_step
   import lcs_pkg::*;
#(
   parameter int MAX_SUBSET = 16,
   parameter int MAX_SET    = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [POS_W-1:0] rsp_element_position,
   output logic [VAL_W-1:0] rsp_element_value,
   output logic             rsp_last_element,
   output logic             rsp_finished,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [VAL_W-1:0] csr_wdata
);

   localparam int         IDX_W = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
   localparam logic [6:0] MAX_K = 7'(MAX_SUBSET);
   localparam logic [7:0] MAX_N = 8'(MAX_SET);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] k_last_ff, k_last_in;
   logic [SET_W-1:0] n_ff, n_in;
   logic             kgtn_ff, kgtn_in;
   logic             flag_ff, flag_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [SET_W-1:0] set_size_ff;
   logic [SUB_W-1:0] subset_size_ff;

   logic [6:0]       k_sat;
   logic [SET_W-1:0] n_sat;
   logic [IDX_W-1:0] k_last_sat;
   logic             k_gt_n;

   logic             mem_we;
   logic [VAL_W-1:0] rd_data;
   logic [VAL_W-1:0] alu_a;
   alu_res_type      alu_res;
   logic             at_last;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff    <= SET_W'(8);
         subset_size_ff <= SUB_W'(3);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SET_SIZE:    set_size_ff    <= csr_wdata;
            CSR_SUBSET_SIZE: subset_size_ff <= csr_wdata[SUB_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp n and k to the supported range
   assign k_sat      = (7'(subset_size_ff) > MAX_K) ? MAX_K : 7'(subset_size_ff);
   assign n_sat      = (8'(set_size_ff) > MAX_N) ? MAX_N[SET_W-1:0] : set_size_ff;
   assign k_last_sat = IDX_W'(k_sat - 7'd1);
   assign k_gt_n     = (k_sat > 7'(n_sat));
   assign at_last    = (idx_ff == k_last_ff);

   lcs_store #(
      .DEPTH (MAX_SUBSET),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx_ff),
      .wr_data (alu_res.incremented),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   lcs_alu #(
      .IDX_W (IDX_W)
   ) u_alu (
      .operand       (alu_a),
      .set_size      (n_ff),
      .position      (idx_ff),
      .last_position (k_last_ff),
      .result        (alu_res)
   );

   // State and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flag_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      k_last_ff <= k_last_in;
      n_ff      <= n_in;
      kgtn_ff   <= kgtn_in;
      val_ff    <= val_in;
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      k_last_in = k_last_ff;
      n_in      = n_ff;
      kgtn_in   = kgtn_ff;
      flag_in   = flag_ff;
      val_in    = val_ff;
      mem_we    = 1'b0;
      alu_a     = rd_data;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in      = n_sat;
               k_last_in = k_last_sat;
               kgtn_in   = k_gt_n;
               if (k_sat == 7'd0) begin
                  // empty subset: no transactions
                  flag_in = 1'b1;
               end else if (req_restart || flag_ff) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else if (k_gt_n) begin
                  flag_in  = 1'b1;
                  idx_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  idx_in   = k_last_sat;
                  state_in = ST_SCAN_RD;
               end
            end
         end

         ST_LOAD: begin
            // write position + 1
            alu_a  = VAL_W'(idx_ff);
            mem_we = 1'b1;
            if (at_last) begin
               flag_in  = kgtn_ff;
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            if (alu_res.below_ceiling) begin
               // bump this element, then refill the tail
               mem_we = 1'b1;
               val_in = alu_res.incremented;
               if (at_last) begin
                  idx_in   = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_REFILL;
               end
            end else if (idx_ff == '0) begin
               // nothing can move: list exhausted
               flag_in  = 1'b1;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end

         ST_REFILL: begin
            alu_a  = val_ff;
            mem_we = 1'b1;
            val_in = alu_res.incremented;
            if (at_last) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response payload comes straight from registers
   assign rsp_element_position = POS_W'(idx_ff);
   assign rsp_element_value    = rd_data;
   assign rsp_last_element     = at_last;
   assign rsp_finished         = flag_ff;

endmodule
